// File: hw/rtl/olr_pkg.sv
// Shared types and constants for the ordered identifier list.
// Request and response structs, operation and status codes, sequencer states.
// No dependencies.
package olr_pkg;

  localparam int DEF_LIST_DEPTH = 64;
  localparam int DEF_ID_WIDTH   = 32;

  localparam int OP_W     = 3;
  localparam int EXT_ID_W = 32;
  localparam int POS_W    = 6;
  localparam int CNT_W    = 7;
  localparam int STAT_W   = 2;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_READ   = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
  localparam logic [OP_W-1:0] OP_MOVE   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [EXT_ID_W-1:0] entity_id;
    logic [POS_W-1:0]    position;
  } olr_req_t;

  typedef struct packed {
    logic [EXT_ID_W-1:0] entity_out;
    logic [POS_W-1:0]    index_out;
    logic                found;
    logic [CNT_W-1:0]    entry_count;
    logic [STAT_W-1:0]   status;
  } olr_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_CHECK,
    S_FIND,
    S_UP,
    S_DOWN,
    S_PLACE,
    S_RESP
  } olr_state_t;

endpackage

// File: hw/rtl/olr_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Used for the list storage. No dependencies.
module olr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/ordered_id_list_reorder.sv
// Top level of the ordered identifier list with move-to-position.
// Depends on olr_pkg and olr_ram.
//
// A request enters on req_valid/req_ready and carries an operation, an
// identifier and a position; every request gives exactly one response on
// rsp_valid/rsp_ready. The block handles one request at a time and holds
// req_ready low from acceptance until its response has been placed in the
// output register, which may still wait to be taken while the next request
// is accepted.
// Append, clear and unknown operations pass the execute state and then the
// response state before reaching the output register; a read passes the
// read state between them. Find reads one entry a cycle until a match or
// the last entry. Move first reads the target, then walks the entries
// below it upwards and, when needed, the entries above it downwards.
// Find and move walk the list through the memory's single read port.
// Reset empties the list at once; memory contents are left as they are.
// While the receiver stalls, a finished response waits in the sequencer
// until the output register is free.
module ordered_id_list_reorder
  import olr_pkg::*;
#(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH,
  parameter int ID_WIDTH   = DEF_ID_WIDTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  olr_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output olr_rsp_t rsp
);

  localparam int AddrW = $clog2(LIST_DEPTH);
  localparam int CntW  = $clog2(LIST_DEPTH + 1);
  localparam int CmpW  = (CntW > POS_W) ? CntW : POS_W;

  olr_state_t state, state_next;

  logic [OP_W-1:0]     op;
  logic [ID_WIDTH-1:0] ident;
  logic [POS_W-1:0]    tgt_pos;
  logic [CntW-1:0]     count;
  logic [CntW-1:0]     scan_addr;
  logic                issue_on;
  logic                moving;
  logic                rd_valid;
  logic [AddrW-1:0]    rd_addr;

  logic [EXT_ID_W-1:0] res_entity;
  logic [POS_W-1:0]    res_index;
  logic                res_found;
  logic [STAT_W-1:0]   res_status;

  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  logic [ID_WIDTH-1:0] mem_wdata;
  logic                mem_re;
  logic [AddrW-1:0]    mem_raddr;
  logic [ID_WIDTH-1:0] rd_data;

  logic             pos_ok;
  logic [AddrW-1:0] pos_a;
  logic             match;
  logic             at_pos;
  logic             at_last;
  logic             rsp_free;

  olr_ram #(
    .WIDTH(ID_WIDTH),
    .DEPTH(LIST_DEPTH)
  ) u_list (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(rd_data)
  );

  assign pos_ok   = CmpW'(tgt_pos) < CmpW'(count);
  assign pos_a    = AddrW'(tgt_pos);
  assign match    = rd_data == ident;
  assign at_pos   = rd_addr == pos_a;
  assign at_last  = CntW'(rd_addr) == count - 1'b1;
  assign rsp_free = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op)
          OP_READ: state_next = pos_ok ? S_READ : S_RESP;
          OP_FIND: state_next = (count != '0) ? S_FIND : S_RESP;
          OP_MOVE: state_next = pos_ok ? S_CHECK : S_RESP;
          default: state_next = S_RESP;
        endcase
      end
      S_READ:  state_next = S_RESP;
      S_CHECK: state_next = match ? S_RESP : S_UP;
      S_FIND: begin
        if (rd_valid && (match || at_last)) begin
          state_next = S_RESP;
        end
      end
      S_UP: begin
        if (rd_valid && at_pos) begin
          state_next = moving ? S_PLACE : S_DOWN;
        end
      end
      S_DOWN: begin
        if (rd_valid && at_pos) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: state_next = S_RESP;
      S_RESP: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos_a;
    mem_wdata = ident;
    mem_re    = 1'b0;
    mem_raddr = scan_addr[AddrW-1:0];
    unique case (state)
      S_IDLE: req_ready = 1'b1;
      S_EXEC: begin
        if (op == OP_APPEND && count < CntW'(LIST_DEPTH)) begin
          mem_we    = 1'b1;
          mem_waddr = count[AddrW-1:0];
        end
        if ((op == OP_READ || op == OP_MOVE) && pos_ok) begin
          mem_re    = 1'b1;
          mem_raddr = pos_a;
        end
      end
      S_FIND: mem_re = issue_on;
      S_UP: begin
        mem_re = issue_on;
        if (rd_valid && moving) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr - 1'b1;
          mem_wdata = rd_data;
        end
      end
      S_DOWN: begin
        mem_re = issue_on;
        if (rd_valid && moving) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr + 1'b1;
          mem_wdata = rd_data;
        end
      end
      S_PLACE: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      issue_on  <= 1'b0;
      moving    <= 1'b0;
      rd_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= mem_re;
      rd_addr  <= mem_raddr;

      if (state == S_RESP && rsp_free) begin
        rsp_valid       <= 1'b1;
        rsp.entity_out  <= res_entity;
        rsp.index_out   <= res_index;
        rsp.found       <= res_found;
        rsp.entry_count <= CNT_W'(count);
        rsp.status      <= res_status;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op      <= req.operation;
            ident   <= ID_WIDTH'(req.entity_id);
            tgt_pos <= req.position;
          end
        end
        S_EXEC: begin
          res_entity <= '0;
          res_index  <= '0;
          res_found  <= 1'b0;
          res_status <= ST_OK;
          moving     <= 1'b0;
          scan_addr  <= '0;
          issue_on   <= (op == OP_FIND) && (count != '0);
          unique case (op)
            OP_APPEND: begin
              if (count < CntW'(LIST_DEPTH)) begin
                count <= count + 1'b1;
              end else begin
                res_status <= ST_FULL;
              end
            end
            OP_MOVE: begin
              if (!pos_ok) begin
                res_status <= ST_RANGE;
              end
            end
            OP_CLEAR: count <= '0;
            default: ;
          endcase
        end
        S_READ: begin
          res_entity <= EXT_ID_W'(rd_data);
          res_found  <= 1'b1;
        end
        S_CHECK: begin
          scan_addr <= '0;
          issue_on  <= !match;
        end
        S_FIND: begin
          if (issue_on) begin
            scan_addr <= scan_addr + 1'b1;
            if (scan_addr == count - 1'b1) begin
              issue_on <= 1'b0;
            end
          end
          if (rd_valid && match) begin
            res_found <= 1'b1;
            res_index <= POS_W'(rd_addr);
          end
        end
        S_UP: begin
          if (issue_on) begin
            scan_addr <= scan_addr + 1'b1;
            if (scan_addr[AddrW-1:0] == pos_a) begin
              issue_on <= 1'b0;
            end
          end
          if (rd_valid && !at_pos && match) begin
            moving <= 1'b1;
          end
          if (rd_valid && at_pos && !moving) begin
            scan_addr <= count - 1'b1;
            issue_on  <= 1'b1;
          end
        end
        S_DOWN: begin
          if (issue_on) begin
            scan_addr <= scan_addr - 1'b1;
            if (scan_addr[AddrW-1:0] == pos_a) begin
              issue_on <= 1'b0;
            end
          end
          if (rd_valid && !at_pos && match) begin
            moving <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(LIST_DEPTH))
    else $error("entry count beyond list depth");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("list written while idle");

  a_shift_only_moving: assert property (@(posedge clk) disable iff (rst)
    ((state == S_UP || state == S_DOWN) && mem_we) |-> moving)
    else $error("entry shifted without a located identifier");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && op == OP_CLEAR) |=> (count == '0))
    else $error("clear left entries in the list");

  a_rsp_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("pending response overwritten");

endmodule
